### hdl/assert_macros.svh
// assertion macros shared by the rdc blocks
// each one is clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RDC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define RDC_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### hdl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants of the radial distortion correction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

	// pipeline depth, input register to output register
	localparam int NumStages = 8;

	localparam int PointW = 16;  // Q0.16 coordinate
	localparam int DeltaW = 17;  // signed offset from center
	localparam int R2W    = 17;  // rounded r2, Q1.16 (max 131068)
	localparam int SqW    = 32;  // one square, Q0.32
	localparam int FactW  = 37;  // signed scale factor, Q.28
	localparam int ProdW  = DeltaW + FactW;
	localparam int FracF  = 28;
	localparam int FracP  = 16;

	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_GAIN_R2  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_GAIN_R4  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CENTER_X = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_CENTER_Y = 2'd3;

	localparam logic [PointW-1:0] CenterReset = 16'h8000;

	typedef logic [NumStages-1:0] rdc_en_t;
	typedef logic signed [DeltaW-1:0] rdc_delta_t;
	typedef logic [R2W-1:0] rdc_r2_t;
	typedef logic signed [FactW-1:0] rdc_fact_t;

endpackage

`default_nettype wire

### hdl/rdc_pipe_ctl.sv
// ----------------------------------------------------------------------------
// rdc_pipe_ctl
// Valid bits and per-stage load enables; bubbles are squeezed out on a stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rdc_pipe_ctl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire            out_ready,
	output rdc_pkg::rdc_en_t stage_en
);
	import rdc_pkg::*;

	rdc_en_t vld_q;

	// a stage loads when it is empty or its item moves on
	always_comb begin
		stage_en[NumStages-1] = !vld_q[NumStages-1] || out_ready;
		for (int k = NumStages - 2; k >= 0; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NumStages; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = stage_en[0];
	assign out_valid = vld_q[NumStages-1];

	`RDC_ASSERT(a_full_stall_blocks_input, (&vld_q && !out_ready) |-> !in_ready, "full stalled pipe takes an item")
	`RDC_ASSERT(a_stalled_item_kept, (vld_q[NumStages-1] && !out_ready) |=> vld_q[NumStages-1], "stalled result lost")
	`RDC_ASSERT_NEVER(a_item_vanishes, vld_q[0] && !stage_en[0] && stage_en[1], "stage one held while stage two loads")

endmodule

`default_nettype wire

### hdl/rdc_radius.sv
// ----------------------------------------------------------------------------
// rdc_radius
// Stages 1 to 3: offsets from the center, squares, rounded r2 in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_radius (
	input  wire                  clk,
	input  wire [2:0]            en,
	input  wire [15:0]           point_x,
	input  wire [15:0]           point_y,
	input  wire [15:0]           center_x,
	input  wire [15:0]           center_y,
	output rdc_pkg::rdc_delta_t  dx,
	output rdc_pkg::rdc_delta_t  dy,
	output rdc_pkg::rdc_r2_t     r2q
);
	import rdc_pkg::*;

	rdc_delta_t dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic [SqW-1:0] sqx_s2, sqy_s2;
	rdc_r2_t r2q_s3;

	rdc_delta_t ndx, ndy;
	logic [PointW-1:0] ax, ay;
	logic [SqW:0] r2sum;

	always_comb begin
		ndx = -dx_s1;
		ndy = -dy_s1;
		ax = dx_s1[DeltaW-1] ? ndx[PointW-1:0] : dx_s1[PointW-1:0];
		ay = dy_s1[DeltaW-1] ? ndy[PointW-1:0] : dy_s1[PointW-1:0];
		// round half up into Q1.16
		r2sum = {1'b0, sqx_s2} + {1'b0, sqy_s2} + (SqW+1)'(1 << (FracP - 1));
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= $signed({1'b0, point_x}) - $signed({1'b0, center_x});
			dy_s1 <= $signed({1'b0, point_y}) - $signed({1'b0, center_y});
		end
		if (en[1]) begin
			sqx_s2 <= ax * ax;
			sqy_s2 <= ay * ay;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
		end
		if (en[2]) begin
			r2q_s3 <= r2sum[SqW:FracP];
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
		end
	end

	assign dx  = dx_s3;
	assign dy  = dy_s3;
	assign r2q = r2q_s3;

endmodule

`default_nettype wire

### hdl/rdc_scale.sv
// ----------------------------------------------------------------------------
// rdc_scale
// Stages 4 to 6: r4 and the scale factor 1 + k0*r2 + k1*r4 in signed Q.28.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_scale (
	input  wire                       clk,
	input  wire [2:0]                 en,
	input  wire signed [15:0]         gain_r2,
	input  wire signed [15:0]         gain_r4,
	input  wire rdc_pkg::rdc_delta_t  dx_in,
	input  wire rdc_pkg::rdc_delta_t  dy_in,
	input  wire rdc_pkg::rdc_r2_t     r2q,
	output rdc_pkg::rdc_delta_t       dx,
	output rdc_pkg::rdc_delta_t       dy,
	output rdc_pkg::rdc_fact_t        fact
);
	import rdc_pkg::*;

	localparam int R4SqW = 2 * R2W;      // r2q squared
	localparam int R4W   = R4SqW - FracP; // rounded r4, Q2.16
	localparam int P0W   = R2W + 17;
	localparam int P1W   = R4W + 17;

	logic [R4SqW-1:0] sq_s4;
	logic signed [P0W-1:0] p0_s4, p0_s5;
	logic signed [P1W-1:0] p1_s5;
	rdc_fact_t fact_s6;
	rdc_delta_t dx_s4, dy_s4, dx_s5, dy_s5, dx_s6, dy_s6;

	logic [R4SqW-1:0] r4sum;
	logic [R4W-1:0] r4q;

	always_comb begin
		r4sum = sq_s4 + R4SqW'(1 << (FracP - 1));
		r4q   = r4sum[R4SqW-1:FracP];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sq_s4 <= r2q * r2q;
			p0_s4 <= gain_r2 * $signed({1'b0, r2q});
			dx_s4 <= dx_in;
			dy_s4 <= dy_in;
		end
		if (en[1]) begin
			p1_s5 <= gain_r4 * $signed({1'b0, r4q});
			p0_s5 <= p0_s4;
			dx_s5 <= dx_s4;
			dy_s5 <= dy_s4;
		end
		if (en[2]) begin
			fact_s6 <= FactW'(1 << FracF) + FactW'(p0_s5) + FactW'(p1_s5);
			dx_s6   <= dx_s5;
			dy_s6   <= dy_s5;
		end
	end

	assign dx   = dx_s6;
	assign dy   = dy_s6;
	assign fact = fact_s6;

endmodule

`default_nettype wire

### hdl/rdc_apply.sv
// ----------------------------------------------------------------------------
// rdc_apply
// Stages 7 and 8: scale the offsets, round, add the center back and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_apply (
	input  wire                       clk,
	input  wire [1:0]                 en,
	input  wire [15:0]                center_x,
	input  wire [15:0]                center_y,
	input  wire rdc_pkg::rdc_delta_t  dx,
	input  wire rdc_pkg::rdc_delta_t  dy,
	input  wire rdc_pkg::rdc_fact_t   fact,
	output logic [15:0]               fixed_x,
	output logic [15:0]               fixed_y,
	output logic                      clipped
);
	import rdc_pkg::*;

	localparam int OffW = ProdW - FracF;
	localparam int SumW = OffW + 1;

	logic signed [ProdW-1:0] mx_s7, my_s7;
	logic [PointW-1:0] fx_s8, fy_s8;
	logic clip_s8;

	logic signed [ProdW-1:0] tx, ty;
	logic signed [SumW-1:0] vx, vy;
	logic [PointW:0] cl_x, cl_y;

	// returns {clip, value}
	function automatic logic [PointW:0] clamp(input logic signed [SumW-1:0] v);
		logic [PointW:0] r;
		if (v[SumW-1]) begin
			r = {1'b1, {PointW{1'b0}}};
		end else if (|v[SumW-2:PointW]) begin
			r = {1'b1, {PointW{1'b1}}};
		end else begin
			r = {1'b0, v[PointW-1:0]};
		end
		return r;
	endfunction

	always_comb begin
		// add half, then floor by taking the upper bits
		tx = mx_s7 + ProdW'(1 << (FracF - 1));
		ty = my_s7 + ProdW'(1 << (FracF - 1));
		// offset is signed, so it is sign extended before the center is added
		vx = $signed(SumW'(center_x)) + SumW'($signed(tx[ProdW-1:FracF]));
		vy = $signed(SumW'(center_y)) + SumW'($signed(ty[ProdW-1:FracF]));
		cl_x = clamp(vx);
		cl_y = clamp(vy);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mx_s7 <= dx * fact;
			my_s7 <= dy * fact;
		end
		if (en[1]) begin
			fx_s8   <= cl_x[PointW-1:0];
			fy_s8   <= cl_y[PointW-1:0];
			clip_s8 <= cl_x[PointW] | cl_y[PointW];
		end
	end

	assign fixed_x = fx_s8;
	assign fixed_y = fy_s8;
	assign clipped = clip_s8;

endmodule

`default_nettype wire

### hdl/radial_distortion_correct.sv
// ----------------------------------------------------------------------------
// radial_distortion_correct
// Two-term radial lens correction of one Q0.16 point per clock.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries point_x, point_y; output channel
// out_valid/out_ready carries fixed_x, fixed_y and clipped.
// Registers gain_r2, gain_r4 (signed Q4.12), center_x, center_y (Q0.16) are
// written through cfg_we/cfg_index/cfg_data. The user must write them only
// while no item is in flight; the block itself does not enforce this.
// Throughput: one item per cycle, sustained as long as out_ready stays high.
// Pipeline: eight register stages from the input to the outputs.
// Stages: offsets, squares, r2 round, r2 squared and k0 product, r4 round
// and k1 product, factor sum, offset times factor, round/add/clamp.
// When the receiver stalls the result holds, and empty stages further up
// keep filling, so in_ready only drops once every stage holds an item.
// Reset clears all valid bits; gains go to zero and the center to 0x8000.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module radial_distortion_correct (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [rdc_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire [15:0]                   cfg_data,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [15:0]                   point_x,
	input  wire [15:0]                   point_y,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [15:0]                  fixed_x,
	output logic [15:0]                  fixed_y,
	output logic                         clipped
);
	import rdc_pkg::*;

	logic signed [15:0] gain_r2_q, gain_r4_q;
	logic [15:0] center_x_q, center_y_q;

	rdc_en_t stage_en;
	rdc_delta_t dx_a, dy_a, dx_b, dy_b;
	rdc_r2_t r2q;
	rdc_fact_t fact;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_r2_q  <= '0;
			gain_r4_q  <= '0;
			center_x_q <= CenterReset;
			center_y_q <= CenterReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_R2:  gain_r2_q  <= cfg_data;
				REG_GAIN_R4:  gain_r4_q  <= cfg_data;
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rdc_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stage_en  (stage_en)
	);

	rdc_radius u_radius (
		.clk      (clk),
		.en       (stage_en[2:0]),
		.point_x  (point_x),
		.point_y  (point_y),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.dx       (dx_a),
		.dy       (dy_a),
		.r2q      (r2q)
	);

	rdc_scale u_scale (
		.clk     (clk),
		.en      (stage_en[5:3]),
		.gain_r2 (gain_r2_q),
		.gain_r4 (gain_r4_q),
		.dx_in   (dx_a),
		.dy_in   (dy_a),
		.r2q     (r2q),
		.dx      (dx_b),
		.dy      (dy_b),
		.fact    (fact)
	);

	rdc_apply u_apply (
		.clk      (clk),
		.en       (stage_en[7:6]),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.dx       (dx_b),
		.dy       (dy_b),
		.fact     (fact),
		.fixed_x  (fixed_x),
		.fixed_y  (fixed_y),
		.clipped  (clipped)
	);

	// a clipped item must sit on a rail in at least one coordinate
	`RDC_ASSERT(a_clip_on_rail, (out_valid && clipped) |-> (fixed_x == 16'h0000 || fixed_x == 16'hffff || fixed_y == 16'h0000 || fixed_y == 16'hffff), "clip flag without a saturated coordinate")

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radial_distortion_correct.
// ----------------------------------------------------------------------------
// Points stream in over in_valid/in_ready from a queue, with random gaps, and
// corrected points are taken over out_valid/out_ready with random stalls.
// Each accepted point is run through an in-bench model of the two-term radial
// correction, and every result is compared with the oldest prediction.
// Registers change only while the pipeline is empty: a few directed settings
// hit saturation, mirroring and off-range centers, then random settings follow.
// ----------------------------------------------------------------------------

module tb;

	import rdc_pkg::*;

	localparam int StallLimit  = 1000;
	localparam int PhaseItems  = 200;
	localparam int RandPhases  = 8;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
	} grid_point_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic        clip;
	} corrected_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = REG_GAIN_R2;
	logic [15:0]        cfg_data = 16'd0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        point_x = 16'd0;
	logic [15:0]        point_y = 16'd0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [15:0]        fixed_x;
	logic [15:0]        fixed_y;
	logic               clipped;

	// register shadow
	logic signed [15:0] gain_k0 = 16'sd0;
	logic signed [15:0] gain_k1 = 16'sd0;
	logic [15:0]        ctr_x = CenterReset;
	logic [15:0]        ctr_y = CenterReset;

	grid_point_t      pending_points[$];
	corrected_point_t expected_points[$];

	int in_gap_max = 0;
	int out_stall_max = 0;
	int gap_left = 0;
	int stall_left = 0;
	logic point_taken = 1'b0;
	logic result_taken = 1'b0;
	int idle_cycles = 0;

	int n_errors = 0;
	int n_points = 0;
	int n_results = 0;
	int n_clipped = 0;
	int n_settings = 0;

	radial_distortion_correct u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.fixed_x   (fixed_x),
		.fixed_y   (fixed_y),
		.clipped   (clipped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// round the offset times factor back to Q0.16, add the center and clamp
	function automatic logic [16:0] scale_axis(longint d, longint fact, longint c);
		longint off;
		longint v;
		off = (d * fact + (64'sd1 <<< (FracF - 1))) >>> FracF;
		v = c + off;
		if (v < 0)
			return {1'b1, 16'h0000};
		if (v > 65535)
			return {1'b1, 16'hFFFF};
		return {1'b0, v[15:0]};
	endfunction

	function automatic corrected_point_t correct_point(grid_point_t p);
		longint dx;
		longint dy;
		longint r2q;
		longint r4q;
		longint fact;
		logic [16:0] ax;
		logic [16:0] ay;
		corrected_point_t res;
		dx = longint'(p.x) - longint'(ctr_x);
		dy = longint'(p.y) - longint'(ctr_y);
		r2q = (dx * dx + dy * dy + 32768) >>> FracP;
		r4q = (r2q * r2q + 32768) >>> FracP;
		fact = (64'sd1 <<< FracF) + longint'(gain_k0) * r2q + longint'(gain_k1) * r4q;
		ax = scale_axis(dx, fact, longint'(ctr_x));
		ay = scale_axis(dy, fact, longint'(ctr_y));
		res.x = ax[15:0];
		res.y = ay[15:0];
		res.clip = ax[16] | ay[16];
		return res;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		n_errors++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// monitor: handshakes are sampled at the rising edge
	always @(posedge clk) begin
		corrected_point_t want;
		point_taken = 1'b0;
		result_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				point_taken = 1'b1;
				n_points++;
				want = correct_point({point_x, point_y});
				expected_points = {expected_points, want};
			end
			if (out_valid && out_ready) begin
				result_taken = 1'b1;
				n_results++;
				if (clipped)
					n_clipped++;
				if (expected_points.size() == 0) begin
					report_mismatch("result with no item pending (fixed_x)", fixed_x, 0);
				end else begin
					want = expected_points.pop_front();
					if (fixed_x !== want.x)
						report_mismatch("fixed_x", fixed_x, want.x);
					if (fixed_y !== want.y)
						report_mismatch("fixed_y", fixed_y, want.y);
					if (clipped !== want.clip)
						report_mismatch("clipped", clipped, want.clip);
				end
			end
			if (point_taken || result_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// driver: one point per item, random gap after each
	always @(negedge clk) begin
		grid_point_t p;
		if (arst_n) begin
			if (in_valid && !point_taken) begin
				// item still waiting, hold it
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_points.size() != 0) begin
				p = pending_points.pop_front();
				point_x <= p.x;
				point_y <= p.y;
				in_valid <= 1'b1;
				gap_left = $urandom_range(0, in_gap_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall after each result
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken)
				stall_left = $urandom_range(0, out_stall_max);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= StallLimit) begin
			$display("%0t: no item moved for %0d cycles", $time, StallLimit);
			$display("** radial_distortion_correct: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_GAIN_R2: begin
				gain_k0 = val;
			end
			REG_GAIN_R4: begin
				gain_k1 = val;
			end
			REG_CENTER_X: begin
				ctr_x = val;
			end
			default: begin
				ctr_y = val;
			end
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_config(logic [15:0] k0, logic [15:0] k1, logic [15:0] cx,
			logic [15:0] cy);
		write_reg(REG_GAIN_R2, k0);
		write_reg(REG_GAIN_R4, k1);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		n_settings++;
	endtask

	// sender holds off until the pipeline is empty, then waits out its depth
	// checked at the rising edge, where the driver's queue and in_valid are settled
	task automatic drain_pipe();
		@(posedge clk);
		while (pending_points.size() != 0 || in_valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (NumStages + 2) @(negedge clk);
	endtask

	task automatic push_point(logic [15:0] x, logic [15:0] y);
		grid_point_t p;
		p.x = x;
		p.y = y;
		pending_points = {pending_points, p};
	endtask

	function automatic logic [15:0] rand_gain();
		int v;
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3, 4: return 16'($urandom);
			default: begin
				v = int'($urandom_range(0, 2047)) - 1024;
				return v[15:0];
			end
		endcase
	endfunction

	function automatic logic [15:0] rand_center();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'($urandom);
			default: return 16'h8000 + 16'($urandom_range(0, 4095)) - 16'd2048;
		endcase
	endfunction

	function automatic logic [15:0] pick_corner_coord(logic [15:0] c);
		case ($urandom_range(0, 2))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return c;
		endcase
	endfunction

	initial begin
		int mode;
		logic [15:0] x;
		logic [15:0] y;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		in_gap_max = 1;
		out_stall_max = 3;

		// reset settings: plain pass-through
		n_settings++;
		push_point(16'h0000, 16'h0000);
		push_point(16'hFFFF, 16'hFFFF);
		push_point(16'h0000, 16'hFFFF);
		push_point(16'hFFFF, 16'h0000);
		push_point(16'h8000, 16'h8000);
		push_point(16'h8001, 16'h7FFF);
		drain_pipe();

		// largest gains: corners saturate high and low
		set_config(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
		push_point(16'h0000, 16'h0000);
		push_point(16'hFFFF, 16'hFFFF);
		push_point(16'd32800, 16'd32768);
		push_point(16'd40000, 16'd30000);
		drain_pipe();

		// most negative k0: factor goes below zero and the point mirrors
		set_config(16'h8000, 16'h0000, 16'h8000, 16'h8000);
		push_point(16'h0000, 16'h0000);
		push_point(16'd57000, 16'd32768);
		push_point(16'd32768, 16'd9000);
		push_point(16'hFFFF, 16'hFFFF);
		drain_pipe();

		// centers outside the stated range
		set_config(16'd4096, 16'h8000, 16'hFFFF, 16'h0000);
		push_point(16'h0000, 16'h0000);
		push_point(16'hFFFF, 16'hFFFF);
		push_point(16'h0000, 16'hFFFF);
		push_point(16'hFFFF, 16'h0000);
		push_point(16'd30000, 16'd30000);
		drain_pipe();

		for (int ph = 0; ph < RandPhases; ph++) begin
			in_gap_max = ph[0] ? 3 : 0;
			out_stall_max = ph[1] ? 3 : 0;
			set_config(rand_gain(), rand_gain(), rand_center(), rand_center());
			for (int i = 0; i < PhaseItems; i++) begin
				mode = $urandom_range(0, 9);
				if (mode < 5) begin
					x = 16'($urandom);
					y = 16'($urandom);
				end else if (mode < 8) begin
					// near the center, where gains stay in range
					x = ctr_x + 16'($urandom_range(0, 8191)) - 16'd4096;
					y = ctr_y + 16'($urandom_range(0, 8191)) - 16'd4096;
				end else if (mode == 8) begin
					x = pick_corner_coord(ctr_x);
					y = pick_corner_coord(ctr_y);
				end else begin
					x = pick_corner_coord(ctr_x);
					y = 16'($urandom);
				end
				push_point(x, y);
				// let the pipeline run dry once mid-phase
				if (i == PhaseItems / 2)
					drain_pipe();
			end
			drain_pipe();
		end

		$display("checked %0d corrected points from %0d items, %0d of them clipped",
			n_results, n_points, n_clipped);
		$display("covered %0d register settings with %0d mismatches", n_settings, n_errors);
		if (n_errors == 0)
			$display("** radial_distortion_correct: PASSED **");
		else
			$display("** radial_distortion_correct: FAILED **");
		$finish;
	end

endmodule
